FILE: sv/chrt_pkg.sv
// shared types and constants for the chained hash record table
package chrt_pkg;
  localparam int unsigned Buckets   = 16;
  localparam int unsigned PoolNodes = 64;
  localparam int unsigned IdxW      = 7;
  localparam int unsigned BktW      = 4;
  localparam int unsigned SlotW     = 6;
  localparam logic [IdxW-1:0] NilIndex = 7'd127;

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdLookup = 2'd1;
  localparam logic [1:0] CmdDelIdYr = 2'd2;
  localparam logic [1:0] CmdDelId  = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StNone  = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  // result kinds: held match record or command summary
  localparam logic [1:0] KindRec = 2'd0;
  localparam logic [1:0] KindSum = 2'd1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] record_id;
    logic [15:0] build_year;
    logic [31:0] area_bits;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_id;
    logic [15:0] found_year;
    logic [31:0] found_area;
    logic [6:0]  removed_count;
    logic        last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch item, start modulo
    logic mod_step;   // one subtract step of modulo
    logic find_free;  // step free scan
    logic do_insert;
    logic set_bucket; // cur = head[bucket]
    logic rd_node;    // register node read at cur
    logic visit;      // process node at cur
    logic next_bkt;   // delete by id: advance bucket
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mod_done;
    logic free_done;
    logic pool_full;
    logic cur_ok;
    logic hit;
    logic last_bkt;
    logic any_lookup;
  } stat_t;
endpackage

FILE: sv/chrt_datapath.sv
// datapath: bucket heads, node pool, chain walk and modulo
module chrt_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  input  chrt_pkg::item_t     item_i,
  input  chrt_pkg::cmd_t      cmd_i,
  output chrt_pkg::stat_t     stat_o,
  output chrt_pkg::item_t     item_o,
  output logic [15:0]         node_id_o,
  output logic [15:0]         node_year_o,
  output logic [31:0]         node_area_o,
  output logic [6:0]          count_o
);
  localparam int unsigned IW = chrt_pkg::IdxW;

  logic [4:0]  bcnt_q;
  logic [IW-1:0] head_q [chrt_pkg::Buckets];
  logic [chrt_pkg::PoolNodes-1:0] used_q;
  logic [IW-1:0] link_mem [chrt_pkg::PoolNodes];
  logic [15:0] id_mem [chrt_pkg::PoolNodes];
  logic [15:0] yr_mem [chrt_pkg::PoolNodes];
  logic [31:0] ar_mem [chrt_pkg::PoolNodes];

  chrt_pkg::item_t item_q;
  logic [15:0] rem_q;
  logic [20:0] div_q;
  logic [4:0]  mcnt_q;
  logic [4:0]  live;
  logic [chrt_pkg::SlotW:0] free_q;
  logic [chrt_pkg::BktW-1:0] bkt_q;
  logic [IW-1:0] cur_q, prev_q;
  logic [6:0] steps_q, count_q;
  logic [IW-1:0] rlink_q;
  logic [15:0] rid_q, ryr_q;
  logic [31:0] rar_q;
  logic [15:0] hid_q, hyr_q;
  logic [31:0] har_q;
  logic hit;
  logic any_q;
  logic [chrt_pkg::SlotW-1:0] cur_s, prev_s;

  assign live = (bcnt_q == 5'd0) ? 5'd1 :
                (bcnt_q > 5'(chrt_pkg::Buckets)) ? 5'(chrt_pkg::Buckets) : bcnt_q;
  assign cur_s  = cur_q[chrt_pkg::SlotW-1:0];
  assign prev_s = prev_q[chrt_pkg::SlotW-1:0];

  assign hit = (item_q.cmd == chrt_pkg::CmdLookup) ? (ryr_q == item_q.build_year) :
               (rid_q == item_q.record_id) &&
               ((item_q.cmd == chrt_pkg::CmdDelId) || (ryr_q == item_q.build_year));

  assign stat_o.mod_done   = (mcnt_q == 5'd0);
  assign stat_o.free_done  = free_q[chrt_pkg::SlotW] || !used_q[free_q[chrt_pkg::SlotW-1:0]];
  assign stat_o.pool_full  = free_q[chrt_pkg::SlotW];
  assign stat_o.cur_ok     = (cur_q < IW'(chrt_pkg::PoolNodes)) && used_q[cur_s] &&
                             (steps_q < 7'(chrt_pkg::PoolNodes));
  assign stat_o.hit        = hit;
  assign stat_o.last_bkt   = (item_q.cmd != chrt_pkg::CmdDelId) ||
                             (bkt_q == chrt_pkg::BktW'(chrt_pkg::Buckets - 1));
  assign stat_o.any_lookup = any_q;
  assign item_o      = item_q;
  assign node_id_o   = hid_q;
  assign node_year_o = hyr_q;
  assign node_area_o = har_q;
  assign count_o     = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q  <= 5'd10;
      used_q  <= '0;
      for (int i = 0; i < chrt_pkg::Buckets; i++) head_q[i] <= chrt_pkg::NilIndex;
      rem_q   <= '0;
      div_q   <= '0;
      mcnt_q  <= '0;
      free_q  <= '0;
      bkt_q   <= '0;
      cur_q   <= chrt_pkg::NilIndex;
      prev_q  <= chrt_pkg::NilIndex;
      steps_q <= '0;
      count_q <= '0;
      any_q   <= 1'b0;
      hid_q   <= '0;
      hyr_q   <= '0;
      har_q   <= '0;
    end else begin
      if (cfg_we_i) bcnt_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        rem_q   <= item_i.build_year;
        div_q   <= {1'b0, live, 15'd0};
        mcnt_q  <= 5'd16;
        free_q  <= '0;
        bkt_q   <= '0;
        count_q <= '0;
        any_q   <= 1'b0;
      end
      // restoring remainder, one quotient bit a cycle
      if (cmd_i.mod_step) begin
        if ({5'd0, rem_q} >= div_q) rem_q <= rem_q - div_q[15:0];
        div_q  <= div_q >> 1;
        mcnt_q <= mcnt_q - 5'd1;
      end
      if (cmd_i.find_free) free_q <= free_q + 1'b1;
      if (cmd_i.do_insert) begin
        used_q[free_q[chrt_pkg::SlotW-1:0]] <= 1'b1;
        head_q[rem_q[chrt_pkg::BktW-1:0]] <= IW'(free_q[chrt_pkg::SlotW-1:0]);
      end
      if (cmd_i.set_bucket) begin
        cur_q   <= (item_q.cmd == chrt_pkg::CmdDelId) ? head_q[bkt_q]
                                                      : head_q[rem_q[chrt_pkg::BktW-1:0]];
        prev_q  <= chrt_pkg::NilIndex;
        steps_q <= '0;
      end
      if (cmd_i.next_bkt) bkt_q <= bkt_q + 1'b1;
      if (cmd_i.visit) begin
        steps_q <= steps_q + 7'd1;
        cur_q   <= rlink_q;
        if (item_q.cmd == chrt_pkg::CmdLookup) begin
          prev_q <= cur_q;
          // hold the match until the next one or the end of the chain
          if (hit) begin
            any_q <= 1'b1;
            hid_q <= rid_q;
            hyr_q <= ryr_q;
            har_q <= rar_q;
          end
        end else if (hit) begin
          used_q[cur_s] <= 1'b0;
          count_q <= count_q + 7'd1;
          if (prev_q == chrt_pkg::NilIndex) begin
            if (item_q.cmd == chrt_pkg::CmdDelId) head_q[bkt_q] <= rlink_q;
            else head_q[rem_q[chrt_pkg::BktW-1:0]] <= rlink_q;
          end
        end else begin
          prev_q <= cur_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (cmd_i.do_insert) begin
      id_mem[free_q[chrt_pkg::SlotW-1:0]]   <= item_q.record_id;
      yr_mem[free_q[chrt_pkg::SlotW-1:0]]   <= item_q.build_year;
      ar_mem[free_q[chrt_pkg::SlotW-1:0]]   <= item_q.area_bits;
      link_mem[free_q[chrt_pkg::SlotW-1:0]] <= head_q[rem_q[chrt_pkg::BktW-1:0]];
    end else if (cmd_i.visit && item_q.cmd != chrt_pkg::CmdLookup && hit &&
                 prev_q != chrt_pkg::NilIndex) begin
      link_mem[prev_s] <= rlink_q;
    end
    if (cmd_i.rd_node) begin
      rlink_q <= link_mem[cur_s];
      rid_q   <= id_mem[cur_s];
      ryr_q   <= yr_mem[cur_s];
      rar_q   <= ar_mem[cur_s];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_insert |-> !free_q[chrt_pkg::SlotW]) else $error("insert with full pool");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_insert |=> used_q[$past(free_q[chrt_pkg::SlotW-1:0])])
    else $error("inserted node not marked used");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.visit |-> stat_o.cur_ok) else $error("visit of invalid node");
endmodule

FILE: sv/chrt_ctrl.sv
// controller state machine for the record table
module chrt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cur_cmd_i,
  input  chrt_pkg::stat_t    stat_i,
  output chrt_pkg::cmd_t     cmd_o,
  output logic               res_valid_o,
  output logic [1:0]         res_kind_o,
  output logic               res_last_o,
  input  logic               res_ready_i
);
  typedef enum logic [7:0] {
    SIdle  = 8'b0000_0001,
    SMod   = 8'b0000_0010,
    SFree  = 8'b0000_0100,
    SBkt   = 8'b0000_1000,
    SRead  = 8'b0001_0000,
    SVisit = 8'b0010_0000,
    SEmit  = 8'b0100_0000,
    SDone  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_kind_o = chrt_pkg::KindRec;
    res_last_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = SMod;
        end
      end
      SMod: begin
        if (!stat_i.mod_done) cmd_o.mod_step = 1'b1;
        else if (cur_cmd_i == chrt_pkg::CmdInsert) state_d = SFree;
        else state_d = SBkt;
      end
      SFree: begin
        if (stat_i.free_done) begin
          if (!stat_i.pool_full) cmd_o.do_insert = 1'b1;
          state_d = SDone;
        end else begin
          cmd_o.find_free = 1'b1;
        end
      end
      SBkt: begin
        cmd_o.set_bucket = 1'b1;
        state_d = SRead;
      end
      SRead: begin
        if (stat_i.cur_ok) begin
          cmd_o.rd_node = 1'b1;
          state_d = SVisit;
        end else if (!stat_i.last_bkt) begin
          cmd_o.next_bkt = 1'b1;
          state_d = SBkt;
        end else begin
          state_d = SDone;
        end
      end
      SVisit: begin
        // a new match first sends out the one held before it
        if (cur_cmd_i == chrt_pkg::CmdLookup && stat_i.hit && stat_i.any_lookup) begin
          state_d = SEmit;
        end else begin
          cmd_o.visit = 1'b1;
          state_d = SRead;
        end
      end
      SEmit: begin
        res_valid_o = 1'b1;
        res_kind_o = chrt_pkg::KindRec;
        res_last_o = 1'b0;
        if (res_ready_i) begin
          cmd_o.visit = 1'b1;
          state_d = SRead;
        end
      end
      SDone: begin
        res_valid_o = 1'b1;
        res_kind_o = (cur_cmd_i == chrt_pkg::CmdLookup && stat_i.any_lookup) ?
                     chrt_pkg::KindRec : chrt_pkg::KindSum;
        res_last_o = 1'b1;
        if (res_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !res_valid_o) else $error("accept while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> res_valid_o) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.do_insert |=> state_q == SDone) else $error("insert not followed by result");
endmodule

FILE: sv/chained_hash_record_table_unit.sv
// top level of the chained hash record table
// channel | dir | handshake            | payload
// s_axis  | in  | tvalid/tready        | tdata {area,year,id,cmd}
// m_axis  | out | tvalid/tready, tlast | tdata {count,area,year,id,status}
// cfg     | in  | cfg_we_i             | bucket_count (5 bits)
// one item at a time: accept in idle, then restoring modulo
// insert scans the pool one node a cycle, then gives one result
// a walk reads then visits each node; each match after the first adds an emit state
// delete by id walks all 16 chains, passing through SBkt and SRead at each chain start
// reset clears heads and used bits at once; a stalled result holds the walk
module chained_hash_record_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // cmd, record_id, build_year, area_bits, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // status, found_id, found_year, found_area,
                                     // removed_count, pad
  output logic        m_axis_tlast
);
  chrt_pkg::item_t item_in, item_q;
  chrt_pkg::cmd_t  cmd;
  chrt_pkg::stat_t stat;
  logic [15:0] nid, nyr;
  logic [31:0] nar;
  logic [6:0]  cnt;
  logic [1:0]  kind;
  logic [1:0]  st;

  assign item_in.cmd        = s_axis_tdata[1:0];
  assign item_in.record_id  = s_axis_tdata[17:2];
  assign item_in.build_year = s_axis_tdata[33:18];
  assign item_in.area_bits  = s_axis_tdata[65:34];

  chrt_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .item_i(item_in), .cmd_i(cmd), .stat_o(stat), .item_o(item_q),
    .node_id_o(nid), .node_year_o(nyr), .node_area_o(nar), .count_o(cnt)
  );

  chrt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cur_cmd_i(item_q.cmd), .stat_i(stat), .cmd_o(cmd),
    .res_valid_o(m_axis_tvalid), .res_kind_o(kind), .res_last_o(m_axis_tlast),
    .res_ready_i(m_axis_tready)
  );

  always_comb begin
    case (item_q.cmd)
      chrt_pkg::CmdInsert: st = stat.pool_full ? chrt_pkg::StFull : chrt_pkg::StOk;
      chrt_pkg::CmdLookup: st = chrt_pkg::StNone;
      default:             st = (cnt != 7'd0) ? chrt_pkg::StOk : chrt_pkg::StNone;
    endcase
  end

  always_comb begin
    m_axis_tdata = '0;
    if (kind == chrt_pkg::KindRec) begin
      m_axis_tdata[1:0]   = chrt_pkg::StOk;
      m_axis_tdata[17:2]  = nid;
      m_axis_tdata[33:18] = nyr;
      m_axis_tdata[65:34] = nar;
    end else begin
      m_axis_tdata[1:0] = st;
      if (item_q.cmd == chrt_pkg::CmdDelIdYr || item_q.cmd == chrt_pkg::CmdDelId)
        m_axis_tdata[72:66] = cnt;
    end
  end
endmodule

FILE: tb/chrt_checker.sv
// checker: watches the streams, predicts table results and compares them
`timescale 1ns / 100ps
module chrt_checker
  import chrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending_count
);
  logic [4:0]  bkt_cnt;
  logic [6:0]  head_q [Buckets];
  logic [6:0]  link_q [PoolNodes];
  logic [15:0] ident_q [PoolNodes];
  logic [15:0] year_q [PoolNodes];
  logic [31:0] area_q [PoolNodes];
  logic        used_q [PoolNodes];
  result_t     expected_q[$];

  assign pending_count = expected_q.size();

  function automatic int live_bkts();
    int bc;
    bc = bkt_cnt;
    if (bc == 0) bc = 1;
    if (bc > Buckets) bc = Buckets;
    return bc;
  endfunction

  function automatic bit node_live(int n);
    return n < PoolNodes && used_q[n];
  endfunction

  function automatic result_t mk(logic [1:0] st, logic [15:0] id, logic [15:0] yr,
                                 logic [31:0] ar, logic [6:0] cnt, logic lst);
    result_t r;
    r.status = st; r.found_id = id; r.found_year = yr;
    r.found_area = ar; r.removed_count = cnt; r.last = lst;
    return r;
  endfunction

  function automatic int unlink_chain(int b, bit by_year, logic [15:0] id,
                                      logic [15:0] yr);
    int prv, cur, nxt, steps, cnt;
    prv = NilIndex; cur = head_q[b]; steps = 0; cnt = 0;
    while (node_live(cur) && steps < PoolNodes) begin
      nxt = link_q[cur];
      steps++;
      if (ident_q[cur] == id && (!by_year || year_q[cur] == yr)) begin
        if (prv == NilIndex) head_q[b] = nxt[6:0];
        else link_q[prv] = nxt[6:0];
        used_q[cur] = 1'b0;
        cnt++;
      end else begin
        prv = cur;
      end
      cur = nxt;
    end
    return cnt;
  endfunction

  task automatic predict_table(item_t it);
    int s, b, cur, steps, n, cnt;
    n = 0;
    case (it.cmd)
      CmdInsert: begin
        for (s = 0; s < PoolNodes && used_q[s]; s++) ;
        if (s >= PoolNodes) begin
          expected_q.push_back(mk(StFull, 0, 0, 0, 0, 1));
        end else begin
          b = it.build_year % live_bkts();
          ident_q[s] = it.record_id; year_q[s] = it.build_year;
          area_q[s] = it.area_bits; link_q[s] = head_q[b];
          used_q[s] = 1'b1; head_q[b] = s[6:0];
          expected_q.push_back(mk(StOk, 0, 0, 0, 0, 1));
        end
      end
      CmdLookup: begin
        cur = head_q[it.build_year % live_bkts()];
        steps = 0;
        while (node_live(cur) && steps < PoolNodes && n < PoolNodes) begin
          steps++;
          if (year_q[cur] == it.build_year) begin
            expected_q.push_back(mk(StOk, ident_q[cur], year_q[cur], area_q[cur], 0, 0));
            n++;
          end
          cur = link_q[cur];
        end
        if (n == 0) expected_q.push_back(mk(StNone, 0, 0, 0, 0, 1));
        else expected_q[$].last = 1'b1;
      end
      default: begin
        cnt = 0;
        if (it.cmd == CmdDelIdYr) begin
          cnt = unlink_chain(it.build_year % live_bkts(), 1'b1, it.record_id,
                             it.build_year);
        end else begin
          for (b = 0; b < Buckets; b++) cnt += unlink_chain(b, 1'b0, it.record_id, 0);
        end
        if (cnt > PoolNodes) cnt = PoolNodes;
        expected_q.push_back(mk(cnt != 0 ? StOk : StNone, 0, 0, 0, cnt[6:0], 1));
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, exp_r;
    item_t   it;
    if (!rst_ni) begin
      bkt_cnt <= 5'd10;
      for (int i = 0; i < Buckets; i++) head_q[i] = NilIndex;
      for (int i = 0; i < PoolNodes; i++) used_q[i] = 1'b0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[1:0];
        got.found_id = m_axis_tdata[17:2];
        got.found_year = m_axis_tdata[33:18];
        got.found_area = m_axis_tdata[65:34];
        got.removed_count = m_axis_tdata[72:66];
        got.last = m_axis_tlast;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.cmd = s_axis_tdata[1:0];
        it.record_id = s_axis_tdata[17:2];
        it.build_year = s_axis_tdata[33:18];
        it.area_bits = s_axis_tdata[65:34];
        predict_table(it);
      end
      if (cfg_we_i) bkt_cnt <= cfg_wdata_i;
    end
  end
endmodule

FILE: tb/tb_top.sv
// testbench top: stimulus, idling phases and verdict for the record table
`timescale 1ns / 100ps
module tb_top;
  import chrt_pkg::*;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count, pending_count;
  int          stall_pct = 0;
  int          gap_pct = 0;
  logic [15:0] id_pool [8];
  logic [15:0] yr_pool [8];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  chained_hash_record_table_unit uut (.*);

  chrt_checker u_chk (.*);

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // tvalid stays high after a transfer so the next item can follow at once
  task automatic send_cmd(logic [1:0] cmd, logic [15:0] id, logic [15:0] yr,
                          logic [31:0] ar);
    bit rdy;
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {6'd0, ar, yr, id, cmd};
    s_axis_tvalid <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  task automatic drain_out();
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_buckets(logic [4:0] v);
    drain_out();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int count);
    logic [1:0]  cmd;
    logic [15:0] id, yr;
    int          r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      cmd = r < 45 ? CmdInsert : r < 75 ? CmdLookup : r < 90 ? CmdDelIdYr : CmdDelId;
      id = id_pool[$urandom_range(7)];
      yr = yr_pool[$urandom_range(7)];
      if ($urandom_range(9) == 0) id = 16'($urandom);
      if ($urandom_range(9) == 0) yr = 16'($urandom_range(300));
      send_cmd(cmd, id, yr, $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      id_pool[i] = 16'($urandom);
      yr_pool[i] = 16'($urandom_range(400));
    end
    id_pool[0] = 16'hFFFF; yr_pool[0] = 16'd0; yr_pool[1] = 16'd16;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_cmd(CmdLookup, 16'd1, 16'd5, 0);
    send_cmd(CmdDelIdYr, 16'd1, 16'd5, 0);
    send_cmd(CmdDelId, 16'd1, 0, 0);
    send_cmd(CmdInsert, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
    send_cmd(CmdInsert, 16'd0, 16'd0, 32'd0);
    send_cmd(CmdInsert, 16'd7, 16'd10, 32'h5A5A5A5A);
    send_cmd(CmdInsert, 16'd7, 16'd10, 32'hA5A5A5A5);
    send_cmd(CmdLookup, 0, 16'd10, 0);
    send_cmd(CmdLookup, 0, 16'd20, 0);
    send_cmd(CmdLookup, 0, 16'hFFFF, 0);
    send_cmd(CmdDelIdYr, 16'd7, 16'd10, 0);
    write_buckets(5'd3);
    send_cmd(CmdLookup, 0, 16'hFFFF, 0);
    send_cmd(CmdDelId, 16'hFFFF, 0, 0);
    for (int i = 0; i < 66; i++) send_cmd(CmdInsert, 16'd9, i[15:0], i);
    send_cmd(CmdDelId, 16'd9, 0, 0);
    write_buckets(5'd0);
    random_phase(60);
    write_buckets(5'd1);
    gap_pct = 81;
    random_phase(60);
    drain_out();
    write_buckets(5'd16);
    gap_pct = 0; stall_pct = 81;
    random_phase(60);
    write_buckets(5'd31);
    gap_pct = 6; stall_pct = 6;
    random_phase(60);
    write_buckets(5'd7);
    gap_pct = 0; stall_pct = 0;
    random_phase(80);
    drain_out();
    if (fail_count == 0) $display("[chained_hash_record_table_unit] OK");
    else $display("[chained_hash_record_table_unit] ERROR");
    $finish;
  end

  initial begin
    #200ms;
    $display("[chained_hash_record_table_unit] ERROR");
    $finish;
  end
endmodule
